### hdl/cbf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the counting Bloom filter.
package cbf_pkg;

  localparam int LOG2_MAX_BYTES = 12;
  localparam int NUM_HASHES     = 5;
  localparam int HASH_W         = 32;
  localparam int CNT_W          = 16;
  localparam int LG_W           = 5;
  localparam int SEL_W          = 15;
  localparam int BIT_W          = 3;
  localparam int BYTE_AW        = LOG2_MAX_BYTES;
  localparam int CNT_AW         = LOG2_MAX_BYTES + BIT_W;
  localparam int HASH_IW        = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;

  localparam logic [LG_W-1:0] LG_RESET = LG_W'(12);

  localparam logic [1:0] OP_TEST = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_READ   = 4'b0100,
    S_MODIFY = 4'b1000
  } state_t;

  // One access to the counter and membership stores.
  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [BYTE_AW-1:0] byte_addr;
    logic [CNT_AW-1:0]  cnt_addr;
    logic [7:0]         byte_wdata;
    logic [CNT_W-1:0]   cnt_wdata;
  } mem_req_t;

  // Mask of the byte address bits in use, with the size clamped to the built size.
  function automatic logic [BYTE_AW-1:0] byte_mask(input logic [LG_W-1:0] lg);
    logic [LG_W-1:0] lg_c;
    lg_c = (lg > LG_W'(LOG2_MAX_BYTES)) ? LG_W'(LOG2_MAX_BYTES) : lg;
    return ~({BYTE_AW{1'b1}} << lg_c);
  endfunction

endpackage

### hdl/cbf_store.sv
`timescale 1ns / 1ps
// Counter memory and membership bit memory with registered read data.
module cbf_store (
  input  logic                          clk,
  input  cbf_pkg::mem_req_t             req,
  output logic [7:0]                    byte_rdata,
  output logic [cbf_pkg::CNT_W-1:0]     cnt_rdata
);

  logic [7:0]                byte_mem [2**cbf_pkg::BYTE_AW];
  logic [cbf_pkg::CNT_W-1:0] cnt_mem  [2**cbf_pkg::CNT_AW];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      byte_mem[req.byte_addr] <= req.byte_wdata;
      cnt_mem[req.cnt_addr]   <= req.cnt_wdata;
    end
    if (req.rd_en) begin
      byte_rdata <= byte_mem[req.byte_addr];
      cnt_rdata  <= cnt_mem[req.cnt_addr];
    end
  end

endmodule

### hdl/counting_bloom_filter.sv
`timescale 1ns / 1ps
// Top level of the counting Bloom filter: sequencer, shared counter unit and stores.
//
//   Channel   Signals                                   Transfer when
//   -------   ---------------------------------------   -------------------------
//   command   start, busy, op, hash_0..hash_4,          start high, busy low
//             bit_select
//   result    done, present                             done high (one cycle)
//   config    cfg_valid, cfg_ready, log2_bytes_in_use   cfg_valid and cfg_ready
//
// While a command runs, busy stays high: every hash gets a read state and then a modify
// state on the single-port store, so a read-modify-write to the counter finishes before
// the next hash reads, and repeated selections see the earlier update.
// The result strobe done comes in the cycle after the last modify cycle, with busy
// already low; a new command may be taken at the end of that same cycle, so one
// command is taken only after the one before it has ended.
// After reset the block sweeps both stores to zero, one counter a cycle, over all 32768
// counters, with busy held high; configuration writes are taken at any time.
// The receiver cannot stall the result, so there is no back-pressure path.
module counting_bloom_filter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       op,
  input  logic [cbf_pkg::HASH_W-1:0]       hash_0,
  input  logic [cbf_pkg::HASH_W-1:0]       hash_1,
  input  logic [cbf_pkg::HASH_W-1:0]       hash_2,
  input  logic [cbf_pkg::HASH_W-1:0]       hash_3,
  input  logic [cbf_pkg::HASH_W-1:0]       hash_4,
  input  logic [cbf_pkg::SEL_W-1:0]        bit_select,
  output logic                             done,
  output logic                             present,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cbf_pkg::LG_W-1:0]         log2_bytes_in_use
);

  cbf_pkg::state_t                 state;
  logic [cbf_pkg::LG_W-1:0]        lg_reg;
  logic [cbf_pkg::CNT_AW-1:0]      clr_addr;
  logic [cbf_pkg::HASH_IW-1:0]     k;
  logic [1:0]                      op_q;
  logic                            present_acc;
  logic [cbf_pkg::BYTE_AW-1:0]     byte_q [cbf_pkg::NUM_HASHES];
  logic [cbf_pkg::BIT_W-1:0]       bsel_q [cbf_pkg::NUM_HASHES];
  logic [cbf_pkg::HASH_W-1:0]      hash_in [5];

  cbf_pkg::mem_req_t               mem_req;
  logic [7:0]                      byte_rdata;
  logic [cbf_pkg::CNT_W-1:0]       cnt_rdata;

  logic [cbf_pkg::BYTE_AW-1:0]     byte_cur;
  logic [cbf_pkg::BIT_W-1:0]       bit_cur;
  logic [cbf_pkg::CNT_W-1:0]       cnt_next;
  logic                            toggle;
  logic                            is_update;
  logic                            last_hash;
  logic                            accept;

  assign hash_in[0] = hash_0;
  assign hash_in[1] = hash_1;
  assign hash_in[2] = hash_2;
  assign hash_in[3] = hash_3;
  assign hash_in[4] = hash_4;

  assign busy      = (state != cbf_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // The address of the current hash, masked to the bytes in use.
  assign byte_cur  = byte_q[k] & cbf_pkg::byte_mask(lg_reg);
  assign bit_cur   = bsel_q[k];
  assign is_update = (op_q == cbf_pkg::OP_ADD) || (op_q == cbf_pkg::OP_DEL);
  assign last_hash = (k == cbf_pkg::HASH_IW'(cbf_pkg::NUM_HASHES - 1));

  // The shared counter unit adds one or all ones, so deletes wrap like adds do.
  assign cnt_next = cnt_rdata + ((op_q == cbf_pkg::OP_DEL) ? {cbf_pkg::CNT_W{1'b1}}
                                                           : cbf_pkg::CNT_W'(1));
  // The membership bit flips whenever the count leaves or reaches zero.
  assign toggle   = (cnt_rdata == '0) || (cnt_next == '0);

  // Store access: the clearing sweep, the read of each hash, and the write-back of
  // an update all share the one port.
  always_comb begin
    mem_req            = '0;
    mem_req.byte_addr  = byte_cur;
    mem_req.cnt_addr   = {byte_cur, bit_cur};
    mem_req.byte_wdata = byte_rdata ^ (8'(toggle) << bit_cur);
    mem_req.cnt_wdata  = cnt_next;
    case (state)
      cbf_pkg::S_CLEAR: begin
        mem_req.wr_en      = 1'b1;
        mem_req.byte_addr  = clr_addr[cbf_pkg::CNT_AW-1:cbf_pkg::BIT_W];
        mem_req.cnt_addr   = clr_addr;
        mem_req.byte_wdata = '0;
        mem_req.cnt_wdata  = '0;
      end
      cbf_pkg::S_READ: begin
        mem_req.rd_en = 1'b1;
      end
      cbf_pkg::S_MODIFY: begin
        mem_req.wr_en = is_update;
      end
      default: begin
        mem_req.rd_en = 1'b0;
      end
    endcase
  end

  cbf_store u_store (
    .clk        (clk),
    .req        (mem_req),
    .byte_rdata (byte_rdata),
    .cnt_rdata  (cnt_rdata)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lg_reg <= cbf_pkg::LG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      lg_reg <= log2_bytes_in_use;
    end
  end

  // Command capture; only the low address bits of each hash can ever be used.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= op;
      for (int i = 0; i < cbf_pkg::NUM_HASHES; i++) begin
        byte_q[i] <= hash_in[i][cbf_pkg::BYTE_AW-1:0];
        bsel_q[i] <= bit_select[cbf_pkg::BIT_W*i +: cbf_pkg::BIT_W];
      end
    end
  end

  // Sequencer: clear sweep, then read and modify for each hash in turn.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= cbf_pkg::S_CLEAR;
      clr_addr    <= '0;
      k           <= '0;
      present_acc <= 1'b0;
      done        <= 1'b0;
      present     <= 1'b0;
    end else begin
      done    <= 1'b0;
      present <= 1'b0;
      case (state)
        cbf_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + cbf_pkg::CNT_AW'(1);
          if (clr_addr == {cbf_pkg::CNT_AW{1'b1}}) begin
            state <= cbf_pkg::S_IDLE;
          end
        end
        cbf_pkg::S_IDLE: begin
          if (start) begin
            k           <= '0;
            present_acc <= 1'b1;
            state       <= cbf_pkg::S_READ;
          end
        end
        cbf_pkg::S_READ: begin
          state <= cbf_pkg::S_MODIFY;
        end
        cbf_pkg::S_MODIFY: begin
          if ((op_q == cbf_pkg::OP_TEST) && !byte_rdata[bit_cur]) begin
            present_acc <= 1'b0;
          end
          if (last_hash) begin
            done    <= 1'b1;
            present <= (op_q == cbf_pkg::OP_TEST) && present_acc && byte_rdata[bit_cur];
            state   <= cbf_pkg::S_IDLE;
          end else begin
            k     <= k + cbf_pkg::HASH_IW'(1);
            state <= cbf_pkg::S_READ;
          end
        end
        default: begin
          state <= cbf_pkg::S_IDLE;
        end
      endcase
    end
  end

  // A result strobe only ever ends the last modify cycle of a command.
  a_done_after_modify: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == cbf_pkg::S_MODIFY))
    else $error("result strobe without a finished command");

  // A present result must come from a membership test.
  a_present_from_test: assert property (@(posedge clk) disable iff (rst)
    present |-> done && $past(op_q == cbf_pkg::OP_TEST))
    else $error("present raised outside a test result");

  // Only add and delete write back during a command.
  a_write_only_update: assert property (@(posedge clk) disable iff (rst)
    (mem_req.wr_en && state == cbf_pkg::S_MODIFY) |->
      (op_q == cbf_pkg::OP_ADD || op_q == cbf_pkg::OP_DEL))
    else $error("store written by a test or an unused op");

  // The hash counter never runs past the last hash while a command is active.
  a_hash_index_range: assert property (@(posedge clk) disable iff (rst)
    (state == cbf_pkg::S_READ || state == cbf_pkg::S_MODIFY) |->
      (k <= cbf_pkg::HASH_IW'(cbf_pkg::NUM_HASHES - 1)))
    else $error("hash index out of range");

endmodule

### tb/tb_counting_bloom_filter.sv
`timescale 1ns / 1ps
// Self-checking testbench for the counting Bloom filter: directed and random commands.
module tb_counting_bloom_filter;

  // The fourth op code is not assigned; the block must leave its stores alone.
  localparam logic [1:0] OP_NONE = 2'd3;

  // The block clears all 32768 counters of its stores after reset, so the watchdog
  // has to allow for that sweep with a wide margin on top.
  localparam int STALL_LIMIT = 150000;

  // One command as the sender sees it.
  typedef struct packed {
    logic [1:0]                                          op;
    logic [cbf_pkg::NUM_HASHES-1:0][cbf_pkg::HASH_W-1:0] hash;
    logic [cbf_pkg::SEL_W-1:0]                           sel;
  } cmd_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic [1:0]                 op;
  logic [cbf_pkg::HASH_W-1:0] hash_0, hash_1, hash_2, hash_3, hash_4;
  logic [cbf_pkg::SEL_W-1:0]  bit_select;
  logic                       done;
  logic                       present;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [cbf_pkg::LG_W-1:0]   log2_bytes_in_use;

  // Shadow copy of the filter: membership bits, per-bit counters and the size register.
  logic [7:0]                 shadow_bits   [0:(1 << cbf_pkg::BYTE_AW) - 1];
  logic [cbf_pkg::CNT_W-1:0]  shadow_counts [0:(1 << cbf_pkg::CNT_AW) - 1];
  logic [cbf_pkg::LG_W-1:0]   shadow_lg;

  // Expected present flags, oldest first, one per accepted command.
  logic              present_q [$];
  // Keys that random traffic has added, so that later tests and deletes can hit them.
  cmd_t              key_pool [$];

  int                mismatch_count = 0;
  int                idle_pct = 0;

  counting_bloom_filter dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .op                (op),
    .hash_0            (hash_0),
    .hash_1            (hash_1),
    .hash_2            (hash_2),
    .hash_3            (hash_3),
    .hash_4            (hash_4),
    .bit_select        (bit_select),
    .done              (done),
    .present           (present),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .log2_bytes_in_use (log2_bytes_in_use)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Applies one command to the shadow filter and returns the present flag it yields.
  // Each hash is handled in turn, so a bit that is selected twice sees the first
  // update before the second one.
  function automatic logic apply_command(
      input logic [1:0]                                          cmd_op,
      input logic [cbf_pkg::NUM_HASHES-1:0][cbf_pkg::HASH_W-1:0] h,
      input logic [cbf_pkg::SEL_W-1:0]                           sel);
    logic [cbf_pkg::BYTE_AW-1:0] mask;
    logic [cbf_pkg::BYTE_AW-1:0] byte_sel;
    logic [cbf_pkg::BIT_W-1:0]   bit_sel;
    logic [cbf_pkg::CNT_AW-1:0]  idx;
    logic [cbf_pkg::CNT_W-1:0]   old_cnt;
    logic [cbf_pkg::CNT_W-1:0]   new_cnt;
    logic                        hit;
    int                          lg_eff;
    // Sizes beyond the built array are clamped; smaller ones shrink the array in use.
    lg_eff = (shadow_lg > cbf_pkg::LOG2_MAX_BYTES) ? cbf_pkg::LOG2_MAX_BYTES
                                                    : int'(shadow_lg);
    mask   = cbf_pkg::BYTE_AW'((32'd1 << lg_eff) - 32'd1);
    hit    = 1'b1;
    for (int k = 0; k < cbf_pkg::NUM_HASHES; k++) begin
      byte_sel = h[k][cbf_pkg::BYTE_AW-1:0] & mask;
      bit_sel  = sel[cbf_pkg::BIT_W*k +: cbf_pkg::BIT_W];
      idx      = {byte_sel, bit_sel};
      case (cmd_op)
        cbf_pkg::OP_TEST: begin
          if (!shadow_bits[byte_sel][bit_sel]) hit = 1'b0;
        end
        cbf_pkg::OP_ADD, cbf_pkg::OP_DEL: begin
          old_cnt = shadow_counts[idx];
          new_cnt = (cmd_op == cbf_pkg::OP_ADD) ? old_cnt + 1'b1 : old_cnt - 1'b1;
          // The bit follows whether the counter is nonzero, wrap included.
          if (old_cnt == '0 || new_cnt == '0) begin
            shadow_bits[byte_sel][bit_sel] = ~shadow_bits[byte_sel][bit_sel];
          end
          shadow_counts[idx] = new_cnt;
        end
        default: begin
        end
      endcase
    end
    return (cmd_op == cbf_pkg::OP_TEST) ? hit : 1'b0;
  endfunction

  // Everything the block accepts is observed here at the rising edge. The result of
  // a command comes only after all of its read and modify states, so checking before
  // predicting in the same edge never mixes the two up.
  always @(posedge clk) begin : monitor
    logic expected;
    if (!rst) begin
      if (done) begin
        if (present_q.size() == 0) begin
          report_mismatch($sformatf("result present=%0b with nothing expected", present));
        end else begin
          expected = present_q.pop_front();
          if (present !== expected) begin
            report_mismatch($sformatf("present=%0b, expected %0b", present, expected));
          end
        end
      end
      if (start && !busy) begin
        present_q.push_back(apply_command(op, {hash_4, hash_3, hash_2, hash_1, hash_0},
                                          bit_select));
      end
      if (cfg_valid && cfg_ready) shadow_lg = log2_bytes_in_use;
    end
  end

  // Ends the run if no transfer of any kind and no result has been seen for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("** counting_bloom_filter: FAILED **");
    $finish;
  end

  function automatic cmd_t random_key(input logic [1:0] cmd_op);
    cmd_t c;
    c.op = cmd_op;
    for (int k = 0; k < cbf_pkg::NUM_HASHES; k++) c.hash[k] = $urandom;
    c.sel = cbf_pkg::SEL_W'($urandom_range(0, (1 << cbf_pkg::SEL_W) - 1));
    return c;
  endfunction

  function automatic cmd_t with_op(input cmd_t c, input logic [1:0] cmd_op);
    c.op = cmd_op;
    return c;
  endfunction

  // Sends one command. Inputs change only at falling edges; before the command is
  // offered, each cycle is an idle one with start low at the current idle percentage.
  // The task returns right after the transfer edge, with start still high, so the
  // next call either replaces the command or drops start.
  task automatic send_cmd(input cmd_t c);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    op         = c.op;
    hash_0     = c.hash[0];
    hash_1     = c.hash[1];
    hash_2     = c.hash[2];
    hash_3     = c.hash[3];
    hash_4     = c.hash[4];
    bit_select = c.sel;
    start      = 1'b1;
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  // Drops start and waits at falling edges until every expected result has come.
  task automatic wait_results_drained();
    @(negedge clk);
    start = 1'b0;
    while (present_q.size() != 0) @(negedge clk);
  endtask

  // Writes the size register once the block has gone idle.
  task automatic write_size(input logic [cbf_pkg::LG_W-1:0] lg);
    wait_results_drained();
    cfg_valid         = 1'b1;
    log2_bytes_in_use = lg;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // A freshly cleared filter holds nothing, not even the all-zero or all-one key.
  task automatic test_empty_filter();
    cmd_t c;
    c.op = cbf_pkg::OP_TEST;
    c.hash = '0;
    c.sel  = '0;
    send_cmd(c);
    c.hash = '1;
    c.sel  = '1;
    send_cmd(c);
  endtask

  task automatic test_add_and_query();
    cmd_t key;
    key = random_key(cbf_pkg::OP_ADD);
    send_cmd(key);
    send_cmd(with_op(key, cbf_pkg::OP_TEST));
    send_cmd(with_op(key, cbf_pkg::OP_DEL));
    send_cmd(with_op(key, cbf_pkg::OP_TEST));
  endtask

  // The unused op code reports zero and must not disturb a stored key.
  task automatic test_unused_op();
    cmd_t key;
    key = random_key(cbf_pkg::OP_ADD);
    send_cmd(key);
    send_cmd(with_op(key, OP_NONE));
    send_cmd(with_op(key, cbf_pkg::OP_TEST));
    send_cmd(with_op(key, cbf_pkg::OP_DEL));
  endtask

  // All five hashes land on the same bit, so one counter is stepped five times.
  task automatic test_repeated_select();
    cmd_t key;
    key.op   = cbf_pkg::OP_ADD;
    key.hash = '1;
    key.sel  = '1;
    send_cmd(key);
    send_cmd(with_op(key, cbf_pkg::OP_TEST));
    send_cmd(with_op(key, cbf_pkg::OP_DEL));
    send_cmd(with_op(key, cbf_pkg::OP_TEST));
  endtask

  // Deleting an absent key steps its one shared counter below zero and sets the bit;
  // adding it back wraps the counter to zero and clears the bit again.
  task automatic test_counter_wrap();
    cmd_t key;
    key.op   = cbf_pkg::OP_DEL;
    key.hash = '0;
    key.sel  = '0;
    send_cmd(key);
    send_cmd(with_op(key, cbf_pkg::OP_TEST));
    send_cmd(with_op(key, cbf_pkg::OP_ADD));
    send_cmd(with_op(key, cbf_pkg::OP_TEST));
  endtask

  // With a size of zero every hash maps to byte zero, so any key with the same
  // bit choices matches. Sizes above the built array are clamped to it.
  task automatic test_size_extremes();
    cmd_t key;
    cmd_t other;
    key   = random_key(cbf_pkg::OP_ADD);
    other = random_key(cbf_pkg::OP_TEST);
    other.sel = key.sel;
    write_size(cbf_pkg::LG_W'(0));
    send_cmd(key);
    send_cmd(other);
    write_size('1);
    send_cmd(with_op(key, cbf_pkg::OP_TEST));
    write_size(cbf_pkg::LG_W'(20));
    send_cmd(key);
    send_cmd(with_op(key, cbf_pkg::OP_TEST));
  endtask

  // Picks the next random command. Most of the traffic works on keys that were
  // added earlier so that tests and deletes reach stored bits; the rest is fresh
  // keys, deletes of absent keys and the unused op code.
  function automatic cmd_t next_random_cmd();
    cmd_t c;
    int   r;
    r = $urandom_range(0, 99);
    if (r < 30 || key_pool.size() == 0) begin
      c = random_key(cbf_pkg::OP_ADD);
      key_pool.push_back(c);
      if (key_pool.size() > 24) void'(key_pool.pop_front());
    end else if (r < 82) begin
      c = key_pool[$urandom_range(0, key_pool.size() - 1)];
      c.op = (r < 40) ? cbf_pkg::OP_ADD : (r < 70) ? cbf_pkg::OP_TEST : cbf_pkg::OP_DEL;
    end else if (r < 90) begin
      c = random_key(cbf_pkg::OP_TEST);
    end else if (r < 95) begin
      c = random_key(cbf_pkg::OP_DEL);
    end else begin
      c = random_key(OP_NONE);
    end
    return c;
  endfunction

  // Random phases, each with its own array size; the sender idles lightly at first,
  // then heavily, then not at all.
  task automatic test_random_traffic();
    logic [cbf_pkg::LG_W-1:0] sizes [6];
    int                       idles [6];
    sizes = '{cbf_pkg::LG_W'(3), cbf_pkg::LG_W'(20), cbf_pkg::LG_W'(1),
              cbf_pkg::LG_W'(12), cbf_pkg::LG_W'(6), cbf_pkg::LG_W'(31)};
    idles = '{31, 31, 79, 79, 0, 0};
    for (int p = 0; p < 6; p++) begin
      write_size(sizes[p]);
      idle_pct = idles[p];
      key_pool.delete();
      repeat (158) send_cmd(next_random_cmd());
    end
  endtask

  initial begin
    rst               = 1'b1;
    start             = 1'b0;
    op                = cbf_pkg::OP_TEST;
    hash_0            = '0;
    hash_1            = '0;
    hash_2            = '0;
    hash_3            = '0;
    hash_4            = '0;
    bit_select        = '0;
    cfg_valid         = 1'b0;
    log2_bytes_in_use = cbf_pkg::LG_RESET;
    foreach (shadow_bits[i]) shadow_bits[i] = '0;
    foreach (shadow_counts[i]) shadow_counts[i] = '0;
    shadow_lg = cbf_pkg::LG_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed checks run with light sender idling and, but for the size test, the reset size.
    idle_pct = 31;
    test_empty_filter();
    test_add_and_query();
    test_unused_op();
    test_repeated_select();
    test_counter_wrap();
    test_size_extremes();
    write_size(cbf_pkg::LG_RESET);
    test_random_traffic();

    // Let the last result come, then leave room for any stray strobe.
    wait_results_drained();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && present_q.size() == 0) begin
      $display("** counting_bloom_filter: PASSED **");
    end else begin
      $display("** counting_bloom_filter: FAILED **");
    end
    $finish;
  end

endmodule

### counting_bloom_filter.f
hdl/cbf_pkg.sv
hdl/cbf_store.sv
hdl/counting_bloom_filter.sv
tb/tb_counting_bloom_filter.sv
